FILE: design/tensor_slice_view_calc_macros.svh
// assertion macros for the slice view calculator
// each check samples on clk and is switched off while rst_n is low
`ifndef TENSOR_SLICE_VIEW_CALC_MACROS_SVH
`define TENSOR_SLICE_VIEW_CALC_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define TSVC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tsvc same-cycle check failed");
// next-cycle implication
`define TSVC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tsvc next-cycle check failed");
`else
`define TSVC_ASSERT_NOW(label, ante, cons)
`define TSVC_ASSERT_NEXT(label, ante, cons)
`endif

`endif

FILE: design/tsvc_pkg.sv
package tsvc_pkg;

  // default dimension limit of one run
  localparam int MAX_DIMS_DEF = 8;

  // field widths
  localparam int EXT_W  = 24;
  localparam int STR_W  = 32;
  localparam int NSTR_W = EXT_W + STR_W;
  localparam int OFS_W  = 60;
  localparam int KEPT_W = 4;
  localparam int POS_W  = 3;
  localparam int ERR_W  = 2;

  // divider iterations, one quotient bit each
  localparam int DIV_STEPS = EXT_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // result kinds
  localparam logic KIND_DESC = 1'b0;
  localparam logic KIND_SUM  = 1'b1;

  // error codes
  typedef enum logic [ERR_W-1:0] {
    ERR_NONE  = 2'd0,
    ERR_RANGE = 2'd1,
    ERR_STEP  = 2'd2,
    ERR_DIMS  = 2'd3
  } err_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_OFS,
    ST_MUL_STR,
    ST_DIV,
    ST_DESC,
    ST_SUM
  } state_t;

endpackage

FILE: design/tensor_slice_view_calc.sv
// Slice view calculator.
// Input channel (in_*): one dimension descriptor per item, outermost first;
// in_last_dim marks the final dimension of an array. Result channel (out_*):
// for each kept dimension a descriptor item (out_kind 0) with the new
// extent, stride and compacted position; after the last dimension a summary
// item (out_kind 1, out_last 1) with byte offset, kept count and error code.
// Both channels move an item when valid is high and stall is low.
// One item at a time runs through a shared 32x24 multiplier (offset term,
// then stride product) and a radix-2 divider giving one quotient bit per
// cycle: a kept dimension passes the two multiplier states, the divider and
// the descriptor state, a dropped one only the two multiplier states, an
// item hit by an error none of them; the last dimension then passes the
// summary state. The next item is taken as soon as the sequencer is back in
// idle, while the last result may still wait in the output register.
// A stalled receiver holds the output register and stops the sequencer at
// its next result. Reset (rst_n low, synchronous) empties the output and
// clears offset, counts and the sticky error; the same clear follows every
// summary item.
`include "tensor_slice_view_calc_macros.svh"

module tensor_slice_view_calc #(
  parameter int MAX_DIMS = tsvc_pkg::MAX_DIMS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // dimension descriptor items
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [tsvc_pkg::EXT_W-1:0]  in_dim_extent,
  input  logic [tsvc_pkg::STR_W-1:0]  in_dim_stride,
  input  logic [tsvc_pkg::EXT_W-1:0]  in_slice_start,
  input  logic [tsvc_pkg::EXT_W-1:0]  in_slice_end,
  input  logic [tsvc_pkg::EXT_W-1:0]  in_slice_step,
  input  logic                        in_drop_dim,
  input  logic                        in_last_dim,
  // result items
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_kind,
  output logic [tsvc_pkg::EXT_W-1:0]  out_new_extent,
  output logic [tsvc_pkg::NSTR_W-1:0] out_new_stride,
  output logic [tsvc_pkg::POS_W-1:0]  out_dim_position,
  output logic [tsvc_pkg::OFS_W-1:0]  out_data_offset,
  output logic [tsvc_pkg::KEPT_W-1:0] out_kept_count,
  output logic [tsvc_pkg::ERR_W-1:0]  out_error_code,
  output logic                        out_last
);

  localparam int DW = $clog2(MAX_DIMS + 1);

  tsvc_pkg::state_t state_r, state_nxt;

  // run state
  logic [tsvc_pkg::OFS_W-1:0]  offset_r;
  logic [tsvc_pkg::KEPT_W-1:0] kept_r;
  logic [DW-1:0]               dims_r;
  tsvc_pkg::err_t              sticky_r;

  // latched item
  logic [tsvc_pkg::STR_W-1:0]  stride_r;
  logic [tsvc_pkg::EXT_W-1:0]  start_r;
  logic [tsvc_pkg::EXT_W-1:0]  step_r;
  logic                        drop_r;
  logic                        last_r;

  // shared multiplier and divider registers
  logic [tsvc_pkg::NSTR_W-1:0]    prod_r;
  logic [tsvc_pkg::EXT_W-1:0]     quo_r;
  logic [tsvc_pkg::EXT_W-1:0]     rem_r;
  logic [tsvc_pkg::DIV_CNT_W-1:0] cnt_r;

  // output register
  logic                        out_valid_r;
  logic                        out_kind_r;
  logic [tsvc_pkg::EXT_W-1:0]  out_ext_r;
  logic [tsvc_pkg::NSTR_W-1:0] out_str_r;
  logic [tsvc_pkg::POS_W-1:0]  out_pos_r;
  logic [tsvc_pkg::OFS_W-1:0]  out_ofs_r;
  logic [tsvc_pkg::KEPT_W-1:0] out_kept_r;
  tsvc_pkg::err_t              out_err_r;
  logic                        out_last_r;

  logic                        in_acc;
  logic                        out_free;
  logic                        run_ok;
  tsvc_pkg::err_t              item_err;
  tsvc_pkg::err_t              sticky_nxt;
  logic [tsvc_pkg::EXT_W-1:0]  span;
  logic [tsvc_pkg::EXT_W-1:0]  mul_b;
  logic [tsvc_pkg::NSTR_W-1:0] mul_p;
  logic [tsvc_pkg::EXT_W:0]    rem_sh;
  logic [tsvc_pkg::EXT_W+1:0]  diff;
  logic                        div_done;
  logic                        load_desc;
  logic                        load_sum;

  // check terms
  logic                        chk_sum_err;
  logic                        chk_desc;
  logic                        st_div;
  logic                        sticky_set;

  assign in_stall = (state_r != tsvc_pkg::ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // error check of the incoming item, first match wins
  always_comb begin
    if ((in_slice_start >= in_dim_extent) || (in_slice_end > in_dim_extent)) begin
      item_err = tsvc_pkg::ERR_RANGE;
    end else if (in_slice_step == '0) begin
      item_err = tsvc_pkg::ERR_STEP;
    end else if (dims_r >= DW'(MAX_DIMS)) begin
      item_err = tsvc_pkg::ERR_DIMS;
    end else begin
      item_err = tsvc_pkg::ERR_NONE;
    end
  end

  assign sticky_nxt = (sticky_r == tsvc_pkg::ERR_NONE) ? item_err : sticky_r;
  assign run_ok     = (sticky_nxt == tsvc_pkg::ERR_NONE);
  assign span       = (in_slice_end > in_slice_start) ? (in_slice_end - in_slice_start) : '0;

  // shared multiplier: start term first, then stride product
  assign mul_b = (state_r == tsvc_pkg::ST_MUL_OFS) ? start_r : step_r;
  assign mul_p = {{tsvc_pkg::EXT_W{1'b0}}, stride_r} * {{tsvc_pkg::STR_W{1'b0}}, mul_b};

  // restoring divider step
  assign rem_sh   = {rem_r, quo_r[tsvc_pkg::EXT_W-1]};
  assign diff     = {1'b0, rem_sh} - {2'b00, step_r};
  assign div_done = (cnt_r == tsvc_pkg::DIV_CNT_W'(tsvc_pkg::DIV_STEPS - 1));

  assign load_desc = (state_r == tsvc_pkg::ST_DESC) && out_free;
  assign load_sum  = (state_r == tsvc_pkg::ST_SUM) && out_free;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tsvc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tsvc_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (run_ok) begin
            state_nxt = tsvc_pkg::ST_MUL_OFS;
          end else if (in_last_dim) begin
            state_nxt = tsvc_pkg::ST_SUM;
          end
        end
      end
      tsvc_pkg::ST_MUL_OFS: begin
        state_nxt = tsvc_pkg::ST_MUL_STR;
      end
      tsvc_pkg::ST_MUL_STR: begin
        if (!drop_r) begin
          state_nxt = tsvc_pkg::ST_DIV;
        end else if (last_r) begin
          state_nxt = tsvc_pkg::ST_SUM;
        end else begin
          state_nxt = tsvc_pkg::ST_IDLE;
        end
      end
      tsvc_pkg::ST_DIV: begin
        if (div_done) begin
          state_nxt = tsvc_pkg::ST_DESC;
        end
      end
      tsvc_pkg::ST_DESC: begin
        if (out_free) begin
          state_nxt = last_r ? tsvc_pkg::ST_SUM : tsvc_pkg::ST_IDLE;
        end
      end
      tsvc_pkg::ST_SUM: begin
        if (out_free) begin
          state_nxt = tsvc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = tsvc_pkg::ST_IDLE;
      end
    endcase
  end

  // run state: counts, sticky error, offset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= '0;
      kept_r   <= '0;
      dims_r   <= '0;
      sticky_r <= tsvc_pkg::ERR_NONE;
    end else if (load_sum) begin
      offset_r <= '0;
      kept_r   <= '0;
      dims_r   <= '0;
      sticky_r <= tsvc_pkg::ERR_NONE;
    end else begin
      if (in_acc) begin
        sticky_r <= sticky_nxt;
        if (dims_r < DW'(MAX_DIMS)) begin
          dims_r <= dims_r + 1'b1;
        end
      end
      if (state_r == tsvc_pkg::ST_MUL_STR) begin
        offset_r <= offset_r + {{(tsvc_pkg::OFS_W - tsvc_pkg::NSTR_W){1'b0}}, prod_r};
      end
      if (load_desc) begin
        kept_r <= kept_r + 1'b1;
      end
    end
  end

  // item latch, multiplier product and divider
  always_ff @(posedge clk) begin
    if (in_acc) begin
      stride_r <= in_dim_stride;
      start_r  <= in_slice_start;
      step_r   <= in_slice_step;
      drop_r   <= in_drop_dim;
      last_r   <= in_last_dim;
      quo_r    <= span;
    end
    if ((state_r == tsvc_pkg::ST_MUL_OFS) || (state_r == tsvc_pkg::ST_MUL_STR)) begin
      prod_r <= mul_p;
    end
    if (state_r == tsvc_pkg::ST_MUL_STR) begin
      rem_r <= '0;
      cnt_r <= '0;
    end else if (state_r == tsvc_pkg::ST_DIV) begin
      if (!diff[tsvc_pkg::EXT_W+1]) begin
        rem_r <= diff[tsvc_pkg::EXT_W-1:0];
      end else begin
        rem_r <= rem_sh[tsvc_pkg::EXT_W-1:0];
      end
      quo_r <= {quo_r[tsvc_pkg::EXT_W-2:0], !diff[tsvc_pkg::EXT_W+1]};
      cnt_r <= cnt_r + 1'b1;
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_desc || load_sum) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // output register payload, ceiling taken from the remainder
  always_ff @(posedge clk) begin
    if (load_desc) begin
      out_kind_r <= tsvc_pkg::KIND_DESC;
      out_ext_r  <= quo_r + {{(tsvc_pkg::EXT_W-1){1'b0}}, (rem_r != '0)};
      out_str_r  <= prod_r;
      out_pos_r  <= kept_r[tsvc_pkg::POS_W-1:0];
      out_ofs_r  <= '0;
      out_kept_r <= '0;
      out_err_r  <= tsvc_pkg::ERR_NONE;
      out_last_r <= 1'b0;
    end else if (load_sum) begin
      out_kind_r <= tsvc_pkg::KIND_SUM;
      out_ext_r  <= '0;
      out_str_r  <= '0;
      out_pos_r  <= '0;
      out_ofs_r  <= (sticky_r == tsvc_pkg::ERR_NONE) ? offset_r : '0;
      out_kept_r <= (sticky_r == tsvc_pkg::ERR_NONE) ? kept_r : '0;
      out_err_r  <= sticky_r;
      out_last_r <= 1'b1;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_new_extent   = out_ext_r;
  assign out_new_stride   = out_str_r;
  assign out_dim_position = out_pos_r;
  assign out_data_offset  = out_ofs_r;
  assign out_kept_count   = out_kept_r;
  assign out_error_code   = out_err_r;
  assign out_last         = out_last_r;

  // check terms
  assign chk_sum_err = out_valid && (out_kind == tsvc_pkg::KIND_SUM) &&
                       (out_error_code != tsvc_pkg::ERR_NONE);
  assign chk_desc    = out_valid && (out_kind == tsvc_pkg::KIND_DESC);
  assign st_div      = (state_r == tsvc_pkg::ST_DIV);
  assign sticky_set  = (sticky_r != tsvc_pkg::ERR_NONE);

  // checks
  `TSVC_ASSERT_NOW(a_sum_err_clean, chk_sum_err, (out_data_offset == '0) && (out_kept_count == '0))
  `TSVC_ASSERT_NOW(a_desc_fields, chk_desc, !out_last && (out_error_code == tsvc_pkg::ERR_NONE))
  `TSVC_ASSERT_NEXT(a_div_exit, st_div, st_div || (state_r == tsvc_pkg::ST_DESC))
  `TSVC_ASSERT_NEXT(a_sticky_holds, sticky_set && !load_sum, sticky_r == $past(sticky_r))

endmodule
